/* hdl/qpht_pkg.sv */
// Package: constants, codes and types for the quadratic probe hash table.
package qpht_pkg;
    localparam int TableSlots = 256;
    localparam int SlotBits = $clog2(TableSlots);
    localparam int CountBits = SlotBits + 1;
    localparam int LoadLimitX4 = 3 * TableSlots;

    localparam logic [1:0] MarkEmpty = 2'd0;
    localparam logic [1:0] MarkUsed = 2'd1;
    localparam logic [1:0] MarkTomb = 2'd2;

    localparam logic [1:0] OpInsert = 2'd0;
    localparam logic [1:0] OpSet = 2'd1;
    localparam logic [1:0] OpGet = 2'd2;
    localparam logic [1:0] OpDelete = 2'd3;

    localparam logic [1:0] StatNormal = 2'd0;
    localparam logic [1:0] StatLoad = 2'd1;
    localparam logic [1:0] StatLimit = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [31:0] key_id;
        logic [31:0] key_hash;
        logic [7:0] scope;
        logic [63:0] value;
    } t_req;

    typedef struct packed {
        logic ok;
        logic [63:0] found_value;
        logic [7:0] found_scope;
        logic [1:0] status;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load_req;   // latch request, set first slot
        logic rd;         // issue slot read
        logic advance;    // move to next probe position
        logic wr_insert;
        logic wr_set;
        logic wr_delete;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clearing;   // post-reset mark clearing pass still running
        logic [1:0] func;
        logic load_full;
        logic count_zero;
        logic [1:0] mark;
        logic key_eq;
        logic have_tomb;
        logic last_probe;
        logic const_hit;
    } t_stat;
endpackage

/* hdl/qpht_if.sv */
// Valid/ready channel interfaces for request, response and configuration words.
interface qpht_req_if;
    logic valid;
    logic ready;
    qpht_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qpht_rsp_if;
    logic valid;
    logic ready;
    qpht_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qpht_cfg_if;
    logic valid;
    logic ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/qpht_datapath.sv */
// Datapath: slot memories, probe position, tombstone tracking and used count.
module qpht_datapath (
    input  logic i_clk,
    input  logic i_rst_n,
    input  qpht_pkg::t_req i_req,
    input  logic [7:0] i_mask,
    input  qpht_pkg::t_cmd i_cmd,
    output qpht_pkg::t_stat o_stat,
    output logic [63:0] o_rd_value,
    output logic [7:0] o_rd_scope
);
    localparam int SB = qpht_pkg::SlotBits;
    localparam int CB = qpht_pkg::CountBits;

    logic [1:0] r_mark [qpht_pkg::TableSlots];
    logic [31:0] r_key_mem [qpht_pkg::TableSlots];
    logic [63:0] r_val_mem [qpht_pkg::TableSlots];
    logic [7:0] r_sc_mem [qpht_pkg::TableSlots];

    qpht_pkg::t_req r_req;
    logic [SB-1:0] r_pos, r_tomb, r_rd_pos;
    logic [SB:0] r_probes;        // probes done, up to TableSlots - 1
    logic [SB-1:0] r_step_sq;     // step^2 mod slots
    logic [SB-1:0] r_step;        // step mod slots
    logic r_have_tomb;
    logic [CB-1:0] r_used;
    logic [1:0] r_rd_mark;
    logic [31:0] r_rd_key;
    logic [63:0] r_rd_val;
    logic [7:0] r_rd_sc;
    logic [SB-1:0] w_addr;
    logic r_clearing;
    logic [SB-1:0] r_clr_pos;

    assign w_addr = r_have_tomb ? r_tomb : r_rd_pos;

    // after reset, one mark per cycle is set empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_pos <= '0;
        end else if (r_clearing) begin
            r_clr_pos <= r_clr_pos + 1'b1;
            if (r_clr_pos == SB'(qpht_pkg::TableSlots - 1)) r_clearing <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mark[r_clr_pos] <= qpht_pkg::MarkEmpty;
        end else if (i_cmd.wr_insert) begin
            r_mark[w_addr] <= qpht_pkg::MarkUsed;
        end else if (i_cmd.wr_delete) begin
            r_mark[r_rd_pos] <= qpht_pkg::MarkTomb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_insert) begin
            r_key_mem[w_addr] <= r_req.key_id;
            r_val_mem[w_addr] <= r_req.value;
            r_sc_mem[w_addr] <= r_req.scope;
        end else if (i_cmd.wr_set) begin
            r_val_mem[r_rd_pos] <= r_req.value;
        end else if (i_cmd.wr_delete) begin
            r_sc_mem[r_rd_pos] <= 8'd0;
        end
        if (i_cmd.rd) begin
            r_rd_key <= r_key_mem[r_pos];
            r_rd_val <= r_val_mem[r_pos];
            r_rd_sc <= r_sc_mem[r_pos];
            r_rd_mark <= r_mark[r_pos];
            r_rd_pos <= r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_have_tomb <= 1'b0;
            r_probes <= '0;
        end else begin
            if (i_cmd.wr_insert && !r_have_tomb) r_used <= r_used + 1'b1;
            if (i_cmd.load_req) begin
                r_req <= i_req;
                r_pos <= i_req.key_hash[SB-1:0];
                r_step <= SB'(1);
                r_step_sq <= SB'(1);
                r_have_tomb <= 1'b0;
                r_probes <= '0;
            end else if (i_cmd.advance) begin
                // (s+1)^2 = s^2 + 2s + 1
                r_pos <= r_pos + r_step_sq;
                r_step_sq <= r_step_sq + {r_step[SB-2:0], 1'b1};
                r_step <= r_step + 1'b1;
                r_probes <= r_probes + 1'b1;
                if (!r_have_tomb && r_rd_mark != qpht_pkg::MarkUsed
                        && r_rd_mark != qpht_pkg::MarkEmpty) begin
                    r_have_tomb <= 1'b1;
                    r_tomb <= r_rd_pos;
                end
            end
        end
    end

    always_comb begin
        o_stat.clearing = r_clearing;
        o_stat.func = r_req.func;
        o_stat.load_full = ({r_used, 2'b00} + (CB+2)'(4)) > (CB+2)'(qpht_pkg::LoadLimitX4);
        o_stat.count_zero = (r_used == '0);
        o_stat.mark = r_rd_mark;
        o_stat.key_eq = (r_rd_key == r_req.key_id);
        o_stat.have_tomb = r_have_tomb;
        o_stat.last_probe = (r_probes == (SB+1)'(qpht_pkg::TableSlots - 1));
        o_stat.const_hit = (r_rd_sc & i_mask) != 8'd0;
    end

    assign o_rd_value = r_rd_val;
    assign o_rd_scope = r_rd_sc;
endmodule

/* hdl/qpht_ctrl.sv */
// Controller: sequences probe reads, decides writes and builds the response word.
module qpht_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output qpht_pkg::t_rsp o_rsp,
    output qpht_pkg::t_cmd o_cmd,
    input  qpht_pkg::t_stat i_stat,
    input  logic [63:0] i_rd_value,
    input  logic [7:0] i_rd_scope
);
    localparam logic [1:0] SIdle = 2'd0;
    localparam logic [1:0] SCheck = 2'd1;
    localparam logic [1:0] SRead = 2'd2;
    localparam logic [1:0] SEval = 2'd3;

    logic [1:0] r_state, n_state;
    logic r_rsp_valid, n_rsp_valid;
    qpht_pkg::t_rsp r_rsp, n_rsp;
    logic hit, free;

    assign o_req_ready = (r_state == SIdle) && !r_rsp_valid && !i_stat.clearing;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp = r_rsp;
    assign hit = (i_stat.mark == qpht_pkg::MarkUsed) && i_stat.key_eq;
    assign free = (i_stat.mark == qpht_pkg::MarkEmpty);

    always_comb begin
        n_state = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_rsp = r_rsp;
        o_cmd = '0;
        unique case (r_state)
            SIdle: begin
                if (i_req_valid && o_req_ready) begin
                    o_cmd.load_req = 1'b1;
                    n_state = SCheck;
                end
            end
            SCheck: begin
                n_rsp = '0;
                if (i_stat.func == qpht_pkg::OpInsert && i_stat.load_full) begin
                    n_rsp.status = qpht_pkg::StatLoad;
                    n_rsp_valid = 1'b1;
                    n_state = SIdle;
                end else if ((i_stat.func == qpht_pkg::OpGet
                        || i_stat.func == qpht_pkg::OpDelete) && i_stat.count_zero) begin
                    n_rsp_valid = 1'b1;
                    n_state = SIdle;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state = SEval;
                end
            end
            SRead: begin
                o_cmd.rd = 1'b1;
                n_state = SEval;
            end
            SEval: begin
                n_rsp = '0;
                if (hit || free) begin
                    n_rsp_valid = 1'b1;
                    n_state = SIdle;
                    unique case (i_stat.func)
                        qpht_pkg::OpInsert: begin
                            if (free) begin
                                o_cmd.wr_insert = 1'b1;
                                n_rsp.ok = 1'b1;
                            end
                        end
                        qpht_pkg::OpSet: begin
                            if (hit && !i_stat.const_hit) begin
                                o_cmd.wr_set = 1'b1;
                                n_rsp.ok = 1'b1;
                            end
                        end
                        qpht_pkg::OpGet: begin
                            if (hit) begin
                                n_rsp.ok = 1'b1;
                                n_rsp.found_value = i_rd_value;
                                n_rsp.found_scope = i_rd_scope;
                            end
                        end
                        default: begin
                            if (hit) begin
                                o_cmd.wr_delete = 1'b1;
                                n_rsp.ok = 1'b1;
                            end
                        end
                    endcase
                end else if (i_stat.last_probe) begin
                    n_rsp.status = qpht_pkg::StatLimit;
                    n_rsp_valid = 1'b1;
                    n_state = SIdle;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state = SRead;
                end
            end
            default: n_state = SIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
        r_rsp <= n_rsp;
    end
endmodule

/* hdl/quadratic_probe_hash_table.sv */
// Top level: quadratic probe hash table with configuration register.
// Flow: an accepted request goes to SCheck, which refuses it before probing or issues
// the first slot read; each probe is judged in SEval and further probes pass SRead.
// The response word is registered; one request is in flight at a time, and the next
// request is accepted the cycle after the response word is taken.
// Reset (synchronous, active low) clears count and scope mask, then a pass marks
// every slot empty while the request channel is held not ready.
module quadratic_probe_hash_table (
    input logic i_clk,
    input logic i_rst_n,
    qpht_req_if.sink req,
    qpht_rsp_if.source rsp,
    qpht_cfg_if.sink cfg
);
    logic [7:0] r_mask;
    qpht_pkg::t_cmd cmd;
    qpht_pkg::t_stat stat;
    logic [63:0] rd_value;
    logic [7:0] rd_scope;

    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mask <= 8'd0;
        else if (cfg.valid) r_mask <= cfg.data;
    end

    qpht_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req.valid), .o_req_ready(req.ready),
        .o_rsp_valid(rsp.valid), .i_rsp_ready(rsp.ready), .o_rsp(rsp.data),
        .o_cmd(cmd), .i_stat(stat), .i_rd_value(rd_value), .i_rd_scope(rd_scope)
    );

    qpht_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req.data), .i_mask(r_mask),
        .i_cmd(cmd), .o_stat(stat), .o_rd_value(rd_value), .o_rd_scope(rd_scope)
    );
endmodule
